[rtl/core/esbf_pkg.sv]
// ----------------------------------------------------------------------------
// esbf_pkg: shared types and constants for the encoder step recorder
// Opcodes, controller states, output selection and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package esbf_pkg;

   localparam int FIFO_BYTES_DEF = 16;
   localparam int OP_W           = 2;
   localparam int CNT_W          = 16;
   localparam int TIME_W         = 32;
   localparam int FILL_W         = 8;
   localparam int TICK_SHIFT     = 10;
   localparam int DIV_STEPS      = CNT_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_CW    = 2'd0,
      OP_CCW   = 2'd1,
      OP_POP   = 2'd2,
      OP_SPEED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_DIV
   } state_type;

   typedef enum logic [2:0] {
      OUT_STEP,
      OUT_EMPTY,
      OUT_POP,
      OUT_SAT,
      OUT_DIV
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        step;
      logic        pop;
      logic        sample;
      logic        div_start;
      logic        div_iter;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   div_zero;
   } sts_type;

endpackage

[rtl/core/encoder_step_bit_fifo.sv]
// ----------------------------------------------------------------------------
// encoder_step_bit_fifo: rotary encoder step recorder with direction FIFO
// Counts steps per direction, queues direction bits, measures step rate.
//
//   channel  ports  payload                                     role
//   req      req_*  opcode, now_ms                              request in
//   rsp      rsp_*  dir_valid, direction, push_dropped, totals,  one response
//                   speed, fill_level                           per request
//
// A step answers from the execute state, a pop from it or after the RAM read
// state, a velocity sample from it or after the 16-bit restoring divider runs.
// One request is in flight at a time; the next is accepted as soon as the
// response register is empty or being drained.
// Synchronous reset clears counters, pointers and the sample history; FIFO
// storage is not cleared. A stalled response holds until taken.
// ----------------------------------------------------------------------------
module encoder_step_bit_fifo #(
   parameter int FIFO_BYTES = esbf_pkg::FIFO_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [esbf_pkg::OP_W-1:0]     req_opcode,
   input  logic [esbf_pkg::TIME_W-1:0]   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_dir_valid,
   output logic                          rsp_direction,
   output logic                          rsp_push_dropped,
   output logic [esbf_pkg::CNT_W-1:0]    rsp_cw_total,
   output logic [esbf_pkg::CNT_W-1:0]    rsp_ccw_total,
   output logic [esbf_pkg::CNT_W-1:0]    rsp_speed,
   output logic [esbf_pkg::FILL_W-1:0]   rsp_fill_level
);
   import esbf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   esbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   esbf_dp #(
      .FIFO_BYTES (FIFO_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_now_ms       (req_now_ms),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_dir_valid    (rsp_dir_valid),
      .rsp_direction    (rsp_direction),
      .rsp_push_dropped (rsp_push_dropped),
      .rsp_cw_total     (rsp_cw_total),
      .rsp_ccw_total    (rsp_ccw_total),
      .rsp_speed        (rsp_speed),
      .rsp_fill_level   (rsp_fill_level)
   );

endmodule

[rtl/core/esbf_ram.sv]
// ----------------------------------------------------------------------------
// esbf_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module esbf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/esbf_ctrl.sv]
// ----------------------------------------------------------------------------
// esbf_ctrl: request sequencer
// Accepts a request, steps the datapath through its operation and owns the
// response handshake.
// ----------------------------------------------------------------------------
module esbf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  esbf_pkg::sts_type sts,
   output esbf_pkg::cmd_type cmd
);
   import esbf_pkg::*;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '{default: '0, out_sel: OUT_STEP};
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (sts.op)
               OP_CW, OP_CCW: begin
                  cmd.step     = 1'b1;
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = OUT_STEP;
                  state_in     = ST_IDLE;
               end
               OP_POP: begin
                  if (sts.empty) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_EMPTY;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = ST_READ;
                  end
               end
               OP_SPEED: begin
                  cmd.sample = 1'b1;
                  if (sts.div_zero) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_SAT;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.div_start = 1'b1;
                     cnt_in        = '0;
                     state_in      = ST_DIV;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_READ: begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_POP;
            state_in     = ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_iter = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_DIV;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/esbf_dp.sv]
// ----------------------------------------------------------------------------
// esbf_dp: step counters, direction FIFO, velocity divider, response register
// Holds all payload state and executes the commands of the sequencer.
// ----------------------------------------------------------------------------
module esbf_dp #(
   parameter int FIFO_BYTES = esbf_pkg::FIFO_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [esbf_pkg::OP_W-1:0]     req_opcode,
   input  logic [esbf_pkg::TIME_W-1:0]   req_now_ms,
   input  esbf_pkg::cmd_type             cmd,
   output esbf_pkg::sts_type             sts,
   output logic                          rsp_dir_valid,
   output logic                          rsp_direction,
   output logic                          rsp_push_dropped,
   output logic [esbf_pkg::CNT_W-1:0]    rsp_cw_total,
   output logic [esbf_pkg::CNT_W-1:0]    rsp_ccw_total,
   output logic [esbf_pkg::CNT_W-1:0]    rsp_speed,
   output logic [esbf_pkg::FILL_W-1:0]   rsp_fill_level
);
   import esbf_pkg::*;

   localparam int CAP    = FIFO_BYTES * 8;
   localparam int PTR_W  = $clog2(CAP);
   localparam int HELD_W = $clog2(CAP + 1);

   // captured request
   op_type              op_ff;
   logic [TIME_W-1:0]   now_ff;

   // architectural state
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [HELD_W-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]    cw_ff, cw_in;
   logic [CNT_W-1:0]    ccw_ff, ccw_in;
   logic [CNT_W-1:0]    prev_ff, prev_in;
   logic [TIME_W-1:0]   last_ff, last_in;

   // divider
   logic [CNT_W-1:0]    dsr_ff, dsr_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    quo_ff, quo_in;
   logic [CNT_W:0]      trial;

   // response register
   logic                dir_valid_ff, dir_valid_in;
   logic                direction_ff, direction_in;
   logic                dropped_ff, dropped_in;
   logic [CNT_W-1:0]    cw_out_ff, ccw_out_ff;
   logic [CNT_W-1:0]    speed_ff, speed_in;
   logic [FILL_W-1:0]   fill_ff;

   logic                full;
   logic                ram_rdata;
   logic [CNT_W-1:0]    total;
   logic [CNT_W-1:0]    delta;
   logic [TIME_W-1:0]   elapsed;
   logic [CNT_W-1:0]    divisor;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(CAP - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full    = (held_ff == HELD_W'(CAP));
   assign total   = cw_ff + ccw_ff;
   assign delta   = total - prev_ff;
   assign elapsed = now_ff - last_ff;
   assign divisor = elapsed[TICK_SHIFT +: CNT_W] + 1'b1;

   assign sts.op       = op_ff;
   assign sts.empty    = (held_ff == '0);
   assign sts.div_zero = (divisor == '0);

   esbf_ram #(
      .WIDTH (1),
      .DEPTH (CAP)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.step && !full),
      .wr_addr (wr_ff),
      .wr_data (op_ff == OP_CW),
      .rd_en   (cmd.pop),
      .rd_addr (rd_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_opcode);
         now_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         held_ff <= '0;
         cw_ff   <= '0;
         ccw_ff  <= '0;
         prev_ff <= '0;
         last_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         held_ff <= held_in;
         cw_ff   <= cw_in;
         ccw_ff  <= ccw_in;
         prev_ff <= prev_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      held_in = held_ff;
      cw_in   = cw_ff;
      ccw_in  = ccw_ff;
      prev_in = prev_ff;
      last_in = last_ff;
      if (cmd.step) begin
         if (op_ff == OP_CW) begin
            cw_in = cw_ff + 1'b1;
         end else begin
            ccw_in = ccw_ff + 1'b1;
         end
         if (!full) begin
            wr_in   = next_pos(wr_ff);
            held_in = held_ff + 1'b1;
         end
      end
      if (cmd.pop) begin
         rd_in   = next_pos(rd_ff);
         held_in = held_ff - 1'b1;
      end
      if (cmd.sample) begin
         prev_in = total;
         last_in = now_ff;
      end
   end

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[CNT_W-1]} - {1'b0, dsr_ff};
      dsr_in = dsr_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_start) begin
         dsr_in = divisor;
         rem_in = '0;
         quo_in = delta;
      end else if (cmd.div_iter) begin
         if (trial[CNT_W]) begin
            rem_in = {rem_ff[CNT_W-2:0], quo_ff[CNT_W-1]};
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         quo_in = {quo_ff[CNT_W-2:0], !trial[CNT_W]};
      end
   end

   always_ff @(posedge clock) begin
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      dir_valid_in = 1'b0;
      direction_in = 1'b0;
      dropped_in   = 1'b0;
      speed_in     = '0;
      unique case (cmd.out_sel)
         OUT_STEP:  dropped_in = full;
         OUT_EMPTY: dir_valid_in = 1'b0;
         OUT_POP: begin
            dir_valid_in = 1'b1;
            direction_in = ram_rdata;
         end
         OUT_SAT:   speed_in = '1;
         OUT_DIV:   speed_in = quo_in;
         default:   speed_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dir_valid_ff <= dir_valid_in;
         direction_ff <= direction_in;
         dropped_ff   <= dropped_in;
         cw_out_ff    <= cw_in;
         ccw_out_ff   <= ccw_in;
         speed_ff     <= speed_in;
         fill_ff      <= FILL_W'(held_in);
      end
   end

   assign rsp_dir_valid    = dir_valid_ff;
   assign rsp_direction    = direction_ff;
   assign rsp_push_dropped = dropped_ff;
   assign rsp_cw_total     = cw_out_ff;
   assign rsp_ccw_total    = ccw_out_ff;
   assign rsp_speed        = speed_ff;
   assign rsp_fill_level   = fill_ff;

endmodule

[tb/sv/encoder_step_bit_fifo_tb.sv]
// ----------------------------------------------------------------------------
// encoder_step_bit_fifo_tb: self-checking bench for the encoder step recorder
// Sends step, pop and velocity-sample requests over the req channel and
// compares every response field against a cycle-free prediction of counters,
// direction FIFO and speed. Covers empty and full FIFO, dropped steps,
// time and divisor wrap, random traffic and a long response stall that
// backs up the request channel.
// ----------------------------------------------------------------------------
module encoder_step_bit_fifo_tb;
   import esbf_pkg::*;

   localparam int FIFO_BITS   = FIFO_BYTES_DEF * 8;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic              dir_valid;
      logic              direction;
      logic              push_dropped;
      logic [CNT_W-1:0]  cw_total;
      logic [CNT_W-1:0]  ccw_total;
      logic [CNT_W-1:0]  speed;
      logic [FILL_W-1:0] fill_level;
   } encoder_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_opcode = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_dir_valid;
   logic              rsp_direction;
   logic              rsp_push_dropped;
   logic [CNT_W-1:0]  rsp_cw_total;
   logic [CNT_W-1:0]  rsp_ccw_total;
   logic [CNT_W-1:0]  rsp_speed;
   logic [FILL_W-1:0] rsp_fill_level;

   encoder_report_type pending_reports[$];
   int                mismatch_count = 0;
   int                idle_cycles = 0;
   logic              quiet = 1'b0;
   logic              hold_off_request = 1'b0;
   int                hold_left = 0;
   int                stall_left = 0;
   logic [TIME_W-1:0] host_ms = '0;

   // predicted block state
   logic              direction_store [FIFO_BITS];
   int                wr_ptr = 0;
   int                rd_ptr = 0;
   int                held_count = 0;
   logic [CNT_W-1:0]  model_cw = '0;
   logic [CNT_W-1:0]  model_ccw = '0;
   logic [CNT_W-1:0]  last_total = '0;
   logic [TIME_W-1:0] last_sample_ms = '0;

   encoder_step_bit_fifo uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dir_valid    (rsp_dir_valid),
      .rsp_direction    (rsp_direction),
      .rsp_push_dropped (rsp_push_dropped),
      .rsp_cw_total     (rsp_cw_total),
      .rsp_ccw_total    (rsp_ccw_total),
      .rsp_speed        (rsp_speed),
      .rsp_fill_level   (rsp_fill_level)
   );

   always #6 clock = ~clock;

   function automatic encoder_report_type predict_report(input op_type op,
                                                          input logic [TIME_W-1:0] now);
      encoder_report_type rep;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] delta;
      logic [CNT_W-1:0] divisor;
      logic [TIME_W-1:0] elapsed;
      rep = '0;
      case (op)
         OP_CW, OP_CCW: begin
            if (op == OP_CW) model_cw = model_cw + 1'b1;
            else model_ccw = model_ccw + 1'b1;
            if (held_count >= FIFO_BITS) begin
               rep.push_dropped = 1'b1;
            end else begin
               direction_store[wr_ptr] = (op == OP_CW);
               wr_ptr = (wr_ptr + 1) % FIFO_BITS;
               held_count++;
            end
         end
         OP_POP: begin
            if (held_count != 0) begin
               rep.dir_valid = 1'b1;
               rep.direction = direction_store[rd_ptr];
               rd_ptr = (rd_ptr + 1) % FIFO_BITS;
               held_count--;
            end
         end
         default: begin
            total   = model_cw + model_ccw;
            delta   = total - last_total;
            elapsed = now - last_sample_ms;
            divisor = CNT_W'((elapsed >> TICK_SHIFT) + 32'd1);
            rep.speed = (divisor == '0) ? '1 : delta / divisor;
            last_total     = total;
            last_sample_ms = now;
         end
      endcase
      rep.cw_total   = model_cw;
      rep.ccw_total  = model_ccw;
      rep.fill_level = FILL_W'(held_count);
      return rep;
   endfunction

   function automatic op_type random_step();
      return ($urandom_range(0, 1) != 0) ? OP_CW : OP_CCW;
   endfunction

   function automatic logic [TIME_W-1:0] next_sample_ms();
      if ($urandom_range(0, 7) == 0) host_ms = $urandom;
      else host_ms = host_ms + $urandom_range(0, 4000);
      return host_ms;
   endfunction

   task automatic send_request(input op_type op, input logic [TIME_W-1:0] now);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_reports.push_back(predict_report(op, now));
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_random(input op_type op);
      send_request(op, (op == OP_SPEED) ? next_sample_ms() : $urandom);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // response side: stalls, long hold-off and checking
   always @(posedge clock) begin
      encoder_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected response");
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("dir_valid", want.dir_valid, rsp_dir_valid);
            compare_field("direction", want.direction, rsp_direction);
            compare_field("push_dropped", want.push_dropped, rsp_push_dropped);
            compare_field("cw_total", want.cw_total, rsp_cw_total);
            compare_field("ccw_total", want.ccw_total, rsp_ccw_total);
            compare_field("speed", want.speed, rsp_speed);
            compare_field("fill_level", want.fill_level, rsp_fill_level);
         end
      end
      if (hold_off_request) begin
         hold_off_request <= 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("encoder_step_bit_fifo_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_empty_start();
      send_request(OP_POP, $urandom);
      send_request(OP_SPEED, '0);
   endtask

   task automatic test_steps_and_pops();
      send_request(OP_CW, '0);
      send_request(OP_CCW, '1);
      send_request(OP_CW, $urandom);
      send_request(OP_CCW, $urandom);
      repeat (5) send_request(OP_POP, $urandom);
   endtask

   task automatic test_velocity();
      repeat (5) send_request(OP_CW, $urandom);
      send_request(OP_SPEED, last_sample_ms + 32'd500);
      repeat (7) send_request(random_step(), $urandom);
      send_request(OP_SPEED, last_sample_ms + 32'd3000);
      // divisor wraps to zero
      send_request(OP_SPEED, last_sample_ms + 32'h03FF_FC00);
      // time runs backwards modulo 2^32
      send_request(OP_SPEED, last_sample_ms - 32'h0010_0000);
      send_request(OP_SPEED, '1);
      send_request(OP_SPEED, '0);
      host_ms = '0;
   endtask

   task automatic test_fifo_full();
      while (held_count > 0) send_request(OP_POP, $urandom);
      repeat (FIFO_BITS) send_request(random_step(), $urandom);
      send_request(OP_CW, $urandom);
      send_request(OP_CCW, $urandom);
      send_request(OP_SPEED, next_sample_ms());
      send_request(OP_CCW, $urandom);
      repeat (FIFO_BITS + 2) send_request(OP_POP, $urandom);
   endtask

   task automatic test_backpressure();
      hold_off_request <= 1'b1;
      repeat (12) send_random(op_type'($urandom_range(0, 3)));
   endtask

   task automatic test_random_traffic();
      int step_share;
      int pick;
      for (int seg = 0; seg < 12; seg++) begin
         if (seg == 9) quiet <= 1'b1;
         step_share = $urandom_range(10, 80);
         repeat (100) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) send_random(OP_SPEED);
            else if (pick < 10 + step_share) send_random(random_step());
            else send_random(OP_POP);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_start();
      test_steps_and_pops();
      test_velocity();
      test_fifo_full();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("encoder_step_bit_fifo_tb OK");
      end else begin
         $display("encoder_step_bit_fifo_tb NOT OK");
      end
      $finish;
   end

endmodule
